/* hw/rtl/hcs_pkg.sv */
package hcs_pkg;

   localparam int MODULUS     = 26;
   localparam int LETTER_W    = 5;
   localparam int ROW_W       = 15;
   localparam int KEY_N       = 9;
   localparam int STEP_W      = 6;
   localparam int STEP_LAST   = 38;
   localparam int PROD_W      = 2 * LETTER_W;
   localparam int RECIP       = 2521;
   localparam int RECIP_SHIFT = 16;
   localparam int QPROD_W     = PROD_W + 12;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_ROW2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 2'd3;

   localparam logic [ROW_W-1:0] KEY_ROW0_RST = 15'd1;
   localparam logic [ROW_W-1:0] KEY_ROW1_RST = 15'd32;
   localparam logic [ROW_W-1:0] KEY_ROW2_RST = 15'd1024;

   typedef enum logic [2:0] {
      SRC_KEY,
      SRC_MAT,
      SRC_DINV,
      SRC_GROUP,
      SRC_CIPHER
   } src_type;

   typedef enum logic [1:0] {
      DST_NONE,
      DST_MAT,
      DST_DET,
      DST_OUT
   } dst_type;

   typedef struct packed {
      src_type    a_src;
      logic [3:0] a_idx;
      src_type    b_src;
      logic [3:0] b_idx;
      logic       sub;
      logic       first;
      dst_type    dst;
      logic [3:0] dst_idx;
      logic       group_end;
   } uop_type;

   // cofactor product operands, two per adjugate entry (plus, then minus)
   localparam logic [3:0] COF_A [18] = '{
      4'd4, 4'd5, 4'd7, 4'd1, 4'd1, 4'd2, 4'd5, 4'd8, 4'd8,
      4'd2, 4'd2, 4'd5, 4'd3, 4'd6, 4'd6, 4'd7, 4'd0, 4'd3
   };
   localparam logic [3:0] COF_B [18] = '{
      4'd8, 4'd7, 4'd2, 4'd8, 4'd5, 4'd4, 4'd6, 4'd3, 4'd0,
      4'd6, 4'd3, 4'd0, 4'd7, 4'd4, 4'd1, 4'd0, 4'd4, 4'd1
   };
   localparam logic [1:0] OUT_COL [9] = '{
      2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2
   };

   function automatic logic [LETTER_W-1:0] red26(input logic [LETTER_W-1:0] x);
      red26 = (x >= LETTER_W'(MODULUS)) ? LETTER_W'(x - LETTER_W'(MODULUS)) : x;
   endfunction

   function automatic logic [LETTER_W-1:0] inv26(input logic [LETTER_W-1:0] d);
      logic [LETTER_W-1:0] r;
      case (d)
         5'd1:    r = 5'd1;
         5'd3:    r = 5'd9;
         5'd5:    r = 5'd21;
         5'd7:    r = 5'd15;
         5'd9:    r = 5'd3;
         5'd11:   r = 5'd19;
         5'd15:   r = 5'd7;
         5'd17:   r = 5'd23;
         5'd19:   r = 5'd11;
         5'd21:   r = 5'd5;
         5'd23:   r = 5'd17;
         5'd25:   r = 5'd25;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   // microcode: adjugate, determinant, scaling by inverse det, output rows
   function automatic uop_type uop_decode(input logic [STEP_W-1:0] step);
      uop_type u;
      int      s;
      int      t;
      s = int'(step);
      u = '{a_src: SRC_KEY, a_idx: 4'd0, b_src: SRC_KEY, b_idx: 4'd0, sub: 1'b0,
            first: 1'b1, dst: DST_NONE, dst_idx: 4'd0, group_end: 1'b0};
      if (s < 18) begin
         u.a_idx   = COF_A[s];
         u.b_idx   = COF_B[s];
         u.sub     = step[0];
         u.first   = !step[0];
         u.dst     = step[0] ? DST_MAT : DST_NONE;
         u.dst_idx = 4'(s >> 1);
      end else if (s < 21) begin
         t         = s - 18;
         u.a_idx   = 4'(t);
         u.b_src   = SRC_MAT;
         u.b_idx   = 4'(3 * t);
         u.first   = (t == 0);
         u.dst     = (t == 2) ? DST_DET : DST_NONE;
      end else if (s < 30) begin
         t         = s - 21;
         u.a_src   = SRC_DINV;
         u.b_src   = SRC_MAT;
         u.b_idx   = 4'(t);
         u.dst     = DST_MAT;
         u.dst_idx = 4'(t);
      end else begin
         t           = (s - 30 > 8) ? 8 : s - 30;
         u.a_src     = SRC_CIPHER;
         u.a_idx     = 4'(t);
         u.b_src     = SRC_GROUP;
         u.b_idx     = {2'b00, OUT_COL[t]};
         u.first     = (OUT_COL[t] == 2'd0);
         u.dst       = (OUT_COL[t] == 2'd2) ? DST_OUT : DST_NONE;
         u.group_end = (t == 8);
      end
      return u;
   endfunction

endpackage

/* hw/rtl/hill_cipher_3x3_stream_core.sv */
// Hill cipher, 3x3 key mod 26, on a stream of letter codes. The first two
// letters of a group are taken in one cycle each. The third starts a 39-step
// microcode run on one shared 5x5 multiplier with mod-26 reduce and
// accumulate; each step is a multiply state and then an accumulate state.
// A step that emits an output item waits while the previous output item
// is still held by rsp_ready low.
// req_ready is low for that run. Decrypt builds the inverse key each group
// (adjugate, determinant, inverse determinant); rsp_key_bad flags a key
// whose determinant has no inverse mod 26, and decrypt then outputs zeros.
// A trailing partial group is held and never emitted.
module hill_cipher_3x3_stream_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [hcs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [hcs_pkg::ROW_W-1:0]            csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [hcs_pkg::LETTER_W-1:0]         req_letter_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [hcs_pkg::LETTER_W-1:0]         rsp_letter_out,
   output logic                                 rsp_group_end,
   output logic                                 rsp_key_bad
);

   localparam int LW = hcs_pkg::LETTER_W;
   localparam int SW = hcs_pkg::STEP_W;
   localparam int PW = hcs_pkg::PROD_W;
   localparam int QW = hcs_pkg::QPROD_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC
   } state_type;

   state_type                  state_ff, state_in;
   logic [SW-1:0]              step_ff, step_in;
   logic [1:0]                 cnt_ff, cnt_in;
   logic [hcs_pkg::ROW_W-1:0]  key_row_ff [3];
   logic [hcs_pkg::ROW_W-1:0]  key_row_in [3];
   logic                       mode_ff, mode_in;
   logic [LW-1:0]              held_ff [2];
   logic [LW-1:0]              held_in [2];
   logic [LW-1:0]              last_ff, last_in;
   logic [PW-1:0]              prod_ff, prod_in;
   logic [LW-1:0]              acc_ff, acc_in;
   logic [LW-1:0]              mat_ff [hcs_pkg::KEY_N];
   logic [LW-1:0]              mat_in [hcs_pkg::KEY_N];
   logic [LW-1:0]              dinv_ff, dinv_in;
   logic                       bad_ff, bad_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]              rsp_letter_ff, rsp_letter_in;
   logic                       rsp_end_ff, rsp_end_in;
   logic                       rsp_bad_ff, rsp_bad_in;

   hcs_pkg::uop_type           uop;
   logic [LW-1:0]              key_mod [hcs_pkg::KEY_N];
   logic [LW-1:0]              grp [3];
   logic [LW-1:0]              opa;
   logic [LW-1:0]              opb;
   logic [QW-1:0]              qprod;
   logic [LW-1:0]              quot;
   logic [LW-1:0]              rem;
   logic [LW-1:0]              base;
   logic [LW:0]                sum;
   logic [LW:0]                diff;
   logic [LW-1:0]              acc_next;
   logic                       out_stall;
   logic                       req_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign uop       = hcs_pkg::uop_decode(step_ff);

   always_comb begin
      for (int i = 0; i < hcs_pkg::KEY_N; i++) begin
         key_mod[i] = hcs_pkg::red26(key_row_ff[i / 3][LW * (i % 3) +: LW]);
      end
      grp[0] = hcs_pkg::red26(held_ff[0]);
      grp[1] = hcs_pkg::red26(held_ff[1]);
      grp[2] = hcs_pkg::red26(last_ff);
   end

   always_comb begin
      case (uop.a_src)
         hcs_pkg::SRC_KEY:    opa = key_mod[uop.a_idx];
         hcs_pkg::SRC_MAT:    opa = mat_ff[uop.a_idx];
         hcs_pkg::SRC_DINV:   opa = dinv_ff;
         hcs_pkg::SRC_CIPHER: opa = mode_ff ? mat_ff[uop.a_idx] : key_mod[uop.a_idx];
         default:             opa = '0;
      endcase
      case (uop.b_src)
         hcs_pkg::SRC_KEY:    opb = key_mod[uop.b_idx];
         hcs_pkg::SRC_MAT:    opb = mat_ff[uop.b_idx];
         hcs_pkg::SRC_GROUP:  opb = (uop.b_idx[1:0] == 2'd3) ? grp[2] : grp[uop.b_idx[1:0]];
         default:             opb = '0;
      endcase
   end

   // mod-26 reduce of the registered product, then add it to or subtract it from the accumulator mod 26
   always_comb begin
      qprod = QW'(prod_ff) * QW'(hcs_pkg::RECIP);
      quot  = LW'(qprod >> hcs_pkg::RECIP_SHIFT);
      rem   = LW'(prod_ff - PW'(quot) * PW'(hcs_pkg::MODULUS));
      base  = uop.first ? '0 : acc_ff;
      sum   = {1'b0, base} + {1'b0, rem};
      diff  = {1'b0, base} - {1'b0, rem};
      if (uop.sub) begin
         acc_next = (base < rem) ? LW'(diff + (LW + 1)'(hcs_pkg::MODULUS)) : LW'(diff);
      end else begin
         acc_next = (sum >= (LW + 1)'(hcs_pkg::MODULUS)) ?
                    LW'(sum - (LW + 1)'(hcs_pkg::MODULUS)) : LW'(sum);
      end
   end

   assign out_stall = (uop.dst == hcs_pkg::DST_OUT) && rsp_valid_ff && !rsp_ready;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cnt_in        = cnt_ff;
      key_row_in    = key_row_ff;
      mode_in       = mode_ff;
      held_in       = held_ff;
      last_in       = last_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      mat_in        = mat_ff;
      dinv_in       = dinv_ff;
      bad_in        = bad_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_letter_in = rsp_letter_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_bad_in    = rsp_bad_ff;

      if (csr_write_en) begin
         case (csr_index)
            hcs_pkg::CSR_KEY_ROW0: key_row_in[0] = csr_wdata;
            hcs_pkg::CSR_KEY_ROW1: key_row_in[1] = csr_wdata;
            hcs_pkg::CSR_KEY_ROW2: key_row_in[2] = csr_wdata;
            hcs_pkg::CSR_MODE:     mode_in = csr_wdata[0];
            default:               mode_in = mode_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (cnt_ff == 2'd2) begin
                  last_in  = req_letter_in;
                  cnt_in   = 2'd0;
                  step_in  = '0;
                  state_in = ST_MUL;
               end else begin
                  held_in[cnt_ff[0]] = req_letter_in;
                  cnt_in             = cnt_ff + 2'd1;
               end
            end
         end
         ST_MUL: begin
            prod_in  = PW'(opa) * PW'(opb);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (!out_stall) begin
               acc_in = acc_next;
               case (uop.dst)
                  hcs_pkg::DST_MAT: mat_in[uop.dst_idx] = acc_next;
                  hcs_pkg::DST_DET: begin
                     dinv_in = hcs_pkg::inv26(acc_next);
                     bad_in  = (hcs_pkg::inv26(acc_next) == '0);
                  end
                  hcs_pkg::DST_OUT: begin
                     rsp_valid_in  = 1'b1;
                     rsp_letter_in = acc_next;
                     rsp_end_in    = uop.group_end;
                     rsp_bad_in    = bad_ff;
                  end
                  default: acc_in = acc_next;
               endcase
               if (step_ff == SW'(hcs_pkg::STEP_LAST)) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in  = step_ff + SW'(1);
                  state_in = ST_MUL;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         cnt_ff        <= 2'd0;
         key_row_ff[0] <= hcs_pkg::KEY_ROW0_RST;
         key_row_ff[1] <= hcs_pkg::KEY_ROW1_RST;
         key_row_ff[2] <= hcs_pkg::KEY_ROW2_RST;
         mode_ff       <= 1'b0;
         held_ff[0]    <= '0;
         held_ff[1]    <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_end_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         cnt_ff        <= cnt_in;
         key_row_ff    <= key_row_in;
         mode_ff       <= mode_in;
         held_ff       <= held_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_end_ff    <= rsp_end_in;
      end
      last_ff       <= last_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      mat_ff        <= mat_in;
      dinv_ff       <= dinv_in;
      bad_ff        <= bad_in;
      rsp_letter_ff <= rsp_letter_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_letter_out = rsp_letter_ff;
   assign rsp_group_end  = rsp_end_ff;
   assign rsp_key_bad    = rsp_bad_ff;

   a_group_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && cnt_ff == 2'd2) |=> (state_ff == ST_MUL && step_ff == '0))
      else $error("third letter did not start the sequencer");

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_letter_ff < LW'(hcs_pkg::MODULUS)))
      else $error("output letter out of range");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (step_ff <= SW'(hcs_pkg::STEP_LAST)))
      else $error("step counter ran past the microcode");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("group count overflow");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && out_stall) |=> (state_ff == ST_ACC && $stable(step_ff)))
      else $error("sequencer advanced while output was blocked");

endmodule
